>>> sv/encb64_pkg.sv
// ----------------------------------------------------------------------------
// encb64_pkg
// Shared types, constants and the symbol table of the base64url encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package encb64_pkg;

  // Default depth of the queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // One unit of work: the first sextet always goes out, the second only
  // when the byte completes a group or ends the message.
  typedef struct packed {
    logic [5:0] sext0;
    logic [5:0] sext1;
    logic       two;
    logic       last;
  } work_t;

  // Map a sextet onto the URL-safe alphabet
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
    logic [7:0] code;
    code = {2'b00, s};
    if (s < 6'd26) begin
      code = 8'h41 + code;
    end else if (s < 6'd52) begin
      code = 8'h61 + (code - 8'd26);
    end else if (s < 6'd62) begin
      code = 8'h30 + (code - 8'd52);
    end else if (s == 6'd62) begin
      code = 8'h2D;
    end else begin
      code = 8'h5F;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

>>> sv/base64url_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64url_stream_encoder
// Unpadded base64url encoder: bytes in, URL-safe ASCII symbols out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one message byte per item, in_last_byte on the final
//   byte of each message. Output channel out_*: one ASCII symbol per item,
//   out_last_symbol on the final symbol of the message. No '=' padding.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low.
// Path: an accepted byte is written into the queue, then into the output
//   register, before its first symbol is valid. A completing or final
//   byte adds a second symbol after the first.
// Throughput: the output register emits one symbol per cycle while
//   out_stall is low, so bytes are taken back to back until the work queue
//   fills; sustained, intake is set by the single output symbol slot.
// Reset: rst_n (synchronous, active low) empties the queue and output
//   register and starts a fresh group.
// Stall: out_stall holds the output register; the queue then fills and
//   in_stall rises while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = encb64_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_symbol,
  output logic            out_last_symbol
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

  encb64_pkg::work_t  front_work;
  encb64_pkg::work_t  head_work;
  encb64_pkg::phase_t phase;
  logic               take;
  logic               pop;
  logic               full;
  logic               empty;
  logic [CNT_W-1:0]   count;

  // Accept whenever the queue has room
  assign in_stall = full;
  assign take     = in_valid && !full;

  // Front: classify the byte and advance the group phase
  encb64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .work      (front_work),
    .phase     (phase)
  );

  // Queue: decouple byte intake from symbol output
  encb64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_work (front_work),
    .pop       (pop),
    .head      (head_work),
    .full      (full),
    .empty     (empty),
    .count     (count)
  );

  // Back: emit one symbol per cycle into the output register when not stalled
  encb64_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head_work),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_last_symbol (out_last_symbol)
  );

  // A final byte always closes the group
  a_last_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_last_byte |=> phase == encb64_pkg::PH_FIRST)
    else $error("group phase not cleared after final byte");

  // The queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // Push without pop grows the queue by one
  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    take && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count out of step with push");

endmodule

`default_nettype wire

>>> sv/encb64_front.sv
// ----------------------------------------------------------------------------
// encb64_front
// Splits each accepted byte into sextets and tracks the group phase.
// ----------------------------------------------------------------------------
`default_nettype none

module encb64_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last_byte,
  output encb64_pkg::work_t        work,
  output encb64_pkg::phase_t       phase
);

  encb64_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]         carry_r, carry_nxt;
  logic [5:0]         carry_fresh;

  // Leftover bits this byte would leave for the next one
  always_comb begin
    unique case (phase_r)
      encb64_pkg::PH_SECOND: carry_fresh = {data_byte[3:0], 2'b00};
      encb64_pkg::PH_THIRD:  carry_fresh = 6'd0;
      default:               carry_fresh = {data_byte[1:0], 4'b0000};
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    if (take) begin
      if (last_byte || phase_r == encb64_pkg::PH_THIRD) begin
        phase_nxt = encb64_pkg::PH_FIRST;
        carry_nxt = 6'd0;
      end else begin
        phase_nxt = (phase_r == encb64_pkg::PH_SECOND) ? encb64_pkg::PH_THIRD
                                                       : encb64_pkg::PH_SECOND;
        carry_nxt = carry_fresh;
      end
    end
  end

  // Work item for the back part
  always_comb begin
    work.last = last_byte;
    unique case (phase_r)
      encb64_pkg::PH_THIRD: begin
        work.sext0 = carry_r | {4'b0000, data_byte[7:6]};
        work.sext1 = data_byte[5:0];
        work.two   = 1'b1;
      end
      encb64_pkg::PH_SECOND: begin
        work.sext0 = carry_r | {2'b00, data_byte[7:4]};
        work.sext1 = carry_fresh;
        work.two   = last_byte;
      end
      default: begin
        work.sext0 = data_byte[7:2];
        work.sext1 = carry_fresh;
        work.two   = last_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= encb64_pkg::PH_FIRST;
      carry_r <= 6'd0;
    end else begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign phase = phase_r;

endmodule

`default_nettype wire

>>> sv/encb64_queue.sv
// ----------------------------------------------------------------------------
// encb64_queue
// Small FIFO of work items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module encb64_queue #(
  parameter int unsigned DEPTH = encb64_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire encb64_pkg::work_t           push_work,
  input  wire logic                        pop,
  output encb64_pkg::work_t                head,
  output logic                             full,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  encb64_pkg::work_t  slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/encb64_back.sv
// ----------------------------------------------------------------------------
// encb64_back
// Emits one or two symbols per work item through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module encb64_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire encb64_pkg::work_t   head,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_symbol,
  output logic                     out_last_symbol
);

  logic       sel_r, sel_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] symbol_r;
  logic       last_r;
  logic       load;
  logic       emit;
  logic [5:0] sext;

  // Refill the output register when it is empty or being taken
  assign load = !valid_r || !out_stall;
  assign emit = load && !empty;
  assign pop  = emit && (sel_r || !head.two);
  assign sext = sel_r ? head.sext1 : head.sext0;

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = emit;
    end
    if (emit) begin
      sel_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      symbol_r <= encb64_pkg::sextet_to_ascii(sext);
      last_r   <= sel_r && head.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_symbol      = symbol_r;
  assign out_last_symbol = last_r;

endmodule

`default_nettype wire
